// ----- rtl/hed_pkg.sv -----
// Package for the HTML character-entity decoder: constants, entity tables,
// shared types and the sequencer state encoding. No dependencies.
package hed_pkg;

  // Default longest span from '&' to ';', not counting the opening '&'.
  localparam int unsigned MAX_SPAN_DEF = 16;

  // Numeric reference value width and limits.
  localparam int unsigned VAL_W = 21;
  localparam logic [VAL_W-1:0] SAT_VALUE = 21'h110000;
  localparam logic [VAL_W-1:0] MAX_CP = 21'h10FFFF;
  localparam logic [VAL_W-1:0] NBSP_CP = 21'h0000A0;

  // Characters with a special role.
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_X_UP = 8'h58;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Named entity table.
  localparam int unsigned NUM_NAMES = 21;
  localparam int unsigned NAME_MAX = 6;
  localparam int unsigned IDX_W = 5;

  localparam logic [8*NAME_MAX-1:0] NAME_STR [NUM_NAMES] = '{
    48'("amp"), 48'("lt"), 48'("gt"), 48'("quot"), 48'("apos"),
    48'("nbsp"), 48'("ensp"), 48'("emsp"), 48'("thinsp"),
    48'("ldquo"), 48'("rdquo"), 48'("lsquo"), 48'("rsquo"),
    48'("mdash"), 48'("ndash"), 48'("hellip"), 48'("bull"),
    48'("middot"), 48'("copy"), 48'("reg"), 48'("trade")
  };
  localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd4, 3'd6, 3'd4, 3'd3, 3'd5
  };
  localparam logic [31:0] REP_STR [NUM_NAMES] = '{
    32'("&"), 32'("<"), 32'(">"), 32'("\""), 32'("'"),
    32'(" "), 32'(" "), 32'(" "), 32'(" "),
    32'("\""), 32'("\""), 32'("'"), 32'("'"),
    32'("-"), 32'("-"), 32'("..."), 32'("*"),
    32'("*"), 32'("(c)"), 32'("(r)"), 32'("(tm)")
  };
  localparam logic [2:0] REP_LEN [NUM_NAMES] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd1, 3'd1, 3'd3, 3'd3, 3'd4
  };

  typedef logic [NUM_NAMES-1:0] name_mask_t;

  // Result of the name compare at the closing ';'.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } name_hit_t;

  // Result of one pass through the digit accumulator.
  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] val;
  } acc_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE, S_TEST, S_OVF, S_RESCAN, S_DEC, S_EMIT, S_FIN, S_FLUSH, S_END
  } state_e;

  // Character j (0 = first) of name n.
  function automatic logic [7:0] name_char(input logic [IDX_W-1:0] n,
                                           input logic [2:0] j);
    logic [8*NAME_MAX-1:0] w;
    logic [2:0]            sh;
    w = '0;
    sh = '0;
    if (n < IDX_W'(NUM_NAMES)) begin
      sh = NAME_LEN[n] - 3'd1 - j;
      w = NAME_STR[n] >> (8 * sh);
    end
    return w[7:0];
  endfunction

  // Replacement text of name n, first byte in the top bits.
  function automatic logic [31:0] rep_word(input logic [IDX_W-1:0] n);
    logic [31:0] w;
    w = '0;
    if (n < IDX_W'(NUM_NAMES)) begin
      w = REP_STR[n] << (8 * (3'd4 - REP_LEN[n]));
    end
    return w;
  endfunction

  function automatic logic [2:0] rep_len(input logic [IDX_W-1:0] n);
    logic [2:0] l;
    l = 3'd1;
    if (n < IDX_W'(NUM_NAMES)) begin
      l = REP_LEN[n];
    end
    return l;
  endfunction

endpackage

// ----- rtl/hed_if.sv -----
// Valid/ready channel interfaces for the entity decoder's input and output.
// Depends on nothing.
interface hed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface hed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output has_byte, output run_last,
                  output text_end, input ready);
  modport sink (input valid, input out_byte, input has_byte, input run_last,
                input text_end, output ready);
endinterface

// ----- rtl/hed_accum.sv -----
// Shared digit accumulator: decodes one digit and folds it into the value.
// Depends on hed_pkg.
module hed_accum (
  input  logic [7:0]                 char_i,
  input  logic                       hex_i,
  input  logic [hed_pkg::VAL_W-1:0]  val_i,
  output hed_pkg::acc_res_t          res_o
);
  import hed_pkg::*;

  logic [3:0]       digit;
  logic             ok;
  logic [VAL_W+3:0] wide;

  // Digit decode for the active base.
  always_comb begin
    ok = 1'b1;
    digit = '0;
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      digit = 4'(char_i - 8'h30);
    end else if (hex_i && char_i >= 8'h61 && char_i <= 8'h66) begin
      digit = 4'(char_i - 8'h57);
    end else if (hex_i && char_i >= 8'h41 && char_i <= 8'h46) begin
      digit = 4'(char_i - 8'h37);
    end else begin
      ok = 1'b0;
    end
  end

  // Multiply by the base with shifts, add the digit and saturate.
  always_comb begin
    if (hex_i) begin
      wide = {val_i, 4'b0000} + (VAL_W+4)'(digit);
    end else begin
      wide = (VAL_W+4)'({val_i, 3'b000}) + (VAL_W+4)'({val_i, 1'b0})
             + (VAL_W+4)'(digit);
    end
    res_o.ok = ok;
    if (val_i >= SAT_VALUE) begin
      res_o.val = val_i;
    end else if (wide > (VAL_W+4)'(SAT_VALUE)) begin
      res_o.val = SAT_VALUE;
    end else begin
      res_o.val = wide[VAL_W-1:0];
    end
  end

endmodule

// ----- rtl/hed_name_match.sv -----
// Named-entity matcher: narrows the candidate set one character at a time
// and reports the surviving name at the closing ';'. Depends on hed_pkg.
module hed_name_match #(
  parameter int unsigned LW = 5
) (
  input  hed_pkg::name_mask_t mask_i,
  input  logic [7:0]          char_i,
  input  logic [LW-1:0]       pos_i,
  input  logic [LW-1:0]       keylen_i,
  output hed_pkg::name_mask_t mask_o,
  output hed_pkg::name_hit_t  hit_o
);
  import hed_pkg::*;

  logic [LW-1:0] j;

  // Character j of the key sits at span position j + 1.
  assign j = pos_i - LW'(1);

  always_comb begin
    for (int n = 0; n < NUM_NAMES; n++) begin
      mask_o[n] = mask_i[n] && (j < LW'(NAME_LEN[n]))
                  && (name_char(IDX_W'(n), j[2:0]) == char_i);
    end
  end

  // Names are distinct, so at most one survivor has the key's length.
  always_comb begin
    hit_o = '0;
    for (int n = 0; n < NUM_NAMES; n++) begin
      if (mask_i[n] && (LW'(NAME_LEN[n]) == keylen_i)) begin
        hit_o.hit = 1'b1;
        hit_o.idx = IDX_W'(n);
      end
    end
  end

endmodule

// ----- rtl/html_entity_decoder.sv -----
// A plain byte or an opening '&' passes through accept, scan, finish and hand-off; a
// byte added to an open span is also tested for ';' and for overflow. A closing ';'
// decodes the span and then emits the replacement bytes; an overlong span emits its '&'
// and passes bytes through on the rescan; end of text flushes the buffered span bytes.
// Output stalls can hold each emitting step; the block works on one item at a time.
// Reset (rst_ni, asynchronous) clears control state; span buffer undefined until written.
module html_entity_decoder
  import hed_pkg::*;
#(
  parameter int unsigned MAX_SPAN = MAX_SPAN_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  hed_in_if.sink          in_i,
  hed_out_if.source       out_o
);

  localparam int unsigned DEPTH = MAX_SPAN + 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  state_e state_q, state_d;

  logic [7:0]       buf_q [DEPTH];
  logic [LW-1:0]    len_q, len_d;
  logic [7:0]       byte_q;
  logic             last_q;
  logic [LW-1:0]    pos_q, pos_d, dlen_q, dlen_d;
  name_mask_t       mask_q, mask_d, mask_nx;
  name_hit_t        hit;
  logic             num_q, num_d, hex_q, hex_d, bad_q, bad_d, got_q, got_d;
  logic [VAL_W-1:0] val_q, val_d;
  acc_res_t         acc;
  logic [31:0]      seq_q, seq_d;
  logic [2:0]       seq_n_q, seq_n_d;
  logic             pend_v_q, pend_v_d;
  logic [7:0]       pend_q, pend_d;

  logic             out_v_q, out_v_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_has_q, out_has_d, out_rl_q, out_rl_d, out_te_q, out_te_d;

  logic             can_push, emit_ok, emit_req, emit_go, shift, wr;
  logic [7:0]       emit_byte;
  logic             dec_last;
  logic [31:0]      utf_w;
  logic [2:0]       utf_n;

  assign can_push = !out_v_q || out_o.ready;
  assign emit_ok = !pend_v_q || can_push;
  assign emit_go = emit_req && emit_ok;
  assign dec_last = (pos_q == dlen_q - LW'(1));

  hed_accum u_accum (
    .char_i (buf_q[0]),
    .hex_i  (hex_q),
    .val_i  (val_q),
    .res_o  (acc)
  );

  hed_name_match #(.LW(LW)) u_match (
    .mask_i   (mask_q),
    .char_i   (buf_q[0]),
    .pos_i    (pos_q),
    .keylen_i (dlen_q - LW'(2)),
    .mask_o   (mask_nx),
    .hit_o    (hit)
  );

  // UTF-8 encoding of the accumulated value, first byte in the top bits.
  always_comb begin
    if (val_q < 21'h80) begin
      utf_w = {val_q[7:0], 24'h0};
      utf_n = 3'd1;
    end else if (val_q < 21'h800) begin
      utf_w = {3'b110, val_q[10:6], 2'b10, val_q[5:0], 16'h0};
      utf_n = 3'd2;
    end else if (val_q < 21'h10000) begin
      utf_w = {4'b1110, val_q[15:12], 2'b10, val_q[11:6], 2'b10, val_q[5:0], 8'h0};
      utf_n = 3'd3;
    end else if (val_q <= MAX_CP) begin
      utf_w = {5'b11110, val_q[20:18], 2'b10, val_q[17:12], 2'b10, val_q[11:6],
               2'b10, val_q[5:0]};
      utf_n = 3'd4;
    end else begin
      utf_w = '0;
      utf_n = 3'd0;
    end
  end

  // Sequencer: next state, buffer control and byte emission.
  always_comb begin
    state_d = state_q;
    len_d = len_q;
    pos_d = pos_q;
    dlen_d = dlen_q;
    mask_d = mask_q;
    num_d = num_q;
    hex_d = hex_q;
    bad_d = bad_q;
    got_d = got_q;
    val_d = val_q;
    seq_d = seq_q;
    seq_n_d = seq_n_q;
    emit_req = 1'b0;
    emit_byte = buf_q[0];
    shift = 1'b0;
    wr = 1'b0;
    out_v_d = out_v_q && !out_o.ready;
    out_byte_d = out_byte_q;
    out_has_d = out_has_q;
    out_rl_d = out_rl_q;
    out_te_d = out_te_q;
    pend_v_d = pend_v_q;
    pend_d = pend_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_BYTE;
        end
      end
      S_BYTE: begin
        if (len_q == '0) begin
          if (byte_q == CH_AMP) begin
            wr = 1'b1;
            len_d = LW'(1);
            state_d = S_FIN;
          end else begin
            emit_req = 1'b1;
            emit_byte = byte_q;
            if (emit_ok) begin
              state_d = S_FIN;
            end
          end
        end else begin
          wr = 1'b1;
          len_d = len_q + LW'(1);
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (byte_q == CH_SEMI) begin
          pos_d = '0;
          dlen_d = len_q;
          mask_d = '1;
          num_d = 1'b0;
          hex_d = 1'b0;
          bad_d = 1'b0;
          got_d = 1'b0;
          val_d = '0;
          state_d = S_DEC;
        end else if (len_q == LW'(DEPTH)) begin
          state_d = S_OVF;
        end else begin
          state_d = S_FIN;
        end
      end
      S_OVF: begin
        // Give up on the span: emit its '&' and rescan the rest.
        emit_req = 1'b1;
        if (emit_ok) begin
          shift = 1'b1;
          len_d = len_q - LW'(1);
          state_d = S_RESCAN;
        end
      end
      S_RESCAN: begin
        if (len_q == '0 || buf_q[0] == CH_AMP) begin
          state_d = S_FIN;
        end else begin
          emit_req = 1'b1;
          if (emit_ok) begin
            shift = 1'b1;
            len_d = len_q - LW'(1);
          end
        end
      end
      S_DEC: begin
        // One span byte per cycle through the matcher and the accumulator.
        shift = 1'b1;
        len_d = len_q - LW'(1);
        pos_d = pos_q + LW'(1);
        if (dec_last) begin
          seq_d = {CH_SPACE, 24'h0};
          seq_n_d = 3'd1;
          if (num_q) begin
            if (!bad_q && got_q && val_q != '0 && val_q != NBSP_CP) begin
              seq_d = utf_w;
              seq_n_d = utf_n;
            end
          end else if (hit.hit) begin
            seq_d = rep_word(hit.idx);
            seq_n_d = rep_len(hit.idx);
          end
          state_d = S_EMIT;
        end else if (pos_q != '0) begin
          mask_d = mask_nx;
          if (pos_q == LW'(1)) begin
            num_d = (dlen_q > LW'(3)) && (buf_q[0] == CH_HASH);
          end else if (num_q) begin
            if (pos_q == LW'(2) && (buf_q[0] == CH_X_LO || buf_q[0] == CH_X_UP)) begin
              hex_d = 1'b1;
            end else if (!acc.ok) begin
              bad_d = 1'b1;
            end else begin
              val_d = acc.val;
              got_d = 1'b1;
            end
          end
        end
      end
      S_EMIT: begin
        if (seq_n_q == '0) begin
          state_d = S_FIN;
        end else begin
          emit_req = 1'b1;
          emit_byte = seq_q[31:24];
          if (emit_ok) begin
            seq_d = {seq_q[23:0], 8'h0};
            seq_n_d = seq_n_q - 3'd1;
          end
        end
      end
      S_FIN: begin
        if (last_q && len_q != '0) begin
          state_d = S_FLUSH;
        end else begin
          state_d = S_END;
        end
      end
      S_FLUSH: begin
        // End of text: the open span goes out verbatim.
        emit_req = 1'b1;
        if (emit_ok) begin
          shift = 1'b1;
          len_d = len_q - LW'(1);
          if (len_q == LW'(1)) begin
            state_d = S_END;
          end
        end
      end
      S_END: begin
        // Close the transaction's run with the held byte or an end marker.
        if (!(pend_v_q || last_q)) begin
          state_d = S_IDLE;
        end else if (can_push) begin
          out_v_d = 1'b1;
          out_byte_d = pend_v_q ? pend_q : 8'h00;
          out_has_d = pend_v_q;
          out_rl_d = 1'b1;
          out_te_d = last_q;
          pend_v_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Hold one byte back so that run_last can be set on the final one.
    if (emit_go) begin
      if (pend_v_q) begin
        out_v_d = 1'b1;
        out_byte_d = pend_q;
        out_has_d = 1'b1;
        out_rl_d = 1'b0;
        out_te_d = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_d = emit_byte;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= '0;
      pend_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q <= len_d;
      pend_v_q <= pend_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      byte_q <= in_i.in_byte;
      last_q <= in_i.end_of_text;
    end
    pos_q <= pos_d;
    dlen_q <= dlen_d;
    mask_q <= mask_d;
    num_q <= num_d;
    hex_q <= hex_d;
    bad_q <= bad_d;
    got_q <= got_d;
    val_q <= val_d;
    seq_q <= seq_d;
    seq_n_q <= seq_n_d;
    pend_q <= pend_d;
    out_byte_q <= out_byte_d;
    out_has_q <= out_has_d;
    out_rl_q <= out_rl_d;
    out_te_q <= out_te_d;
  end

  // Span buffer: appended at the fill level, drained from the front.
  always_ff @(posedge clk_i) begin
    if (shift) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        buf_q[k] <= buf_q[k+1];
      end
    end else if (wr) begin
      buf_q[IW'(len_q)] <= byte_q;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_v_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.has_byte = out_has_q;
  assign out_o.run_last = out_rl_q;
  assign out_o.text_end = out_te_q;

endmodule

// ----- rtl/hed_checker.sv -----
// Port-level checks for the entity decoder and the bind that attaches them.
// Depends on html_entity_decoder and hed_if.
module hed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       has_byte_i,
  input logic       run_last_i,
  input logic       text_end_i
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(has_byte_i))
    else $error("result changed while stalled");

  // One input item is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

  // An end marker closes both the run and the text and carries a zero byte.
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_byte_i |-> run_last_i && text_end_i && out_byte_i == 8'h00)
    else $error("malformed end marker");

  // The end of text is always the end of a run.
  a_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && text_end_i |-> run_last_i)
    else $error("text end without run end");

endmodule

bind html_entity_decoder hed_checker u_hed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .has_byte_i  (out_o.has_byte),
  .run_last_i  (out_o.run_last),
  .text_end_i  (out_o.text_end)
);
